[hdl/ect_pkg.sv]
// Shared types, constants and duration tables for the encoder countdown timer.
`default_nettype none

package ect_pkg;

  // Number of selectable durations and the width of the selection index.
  localparam int OPTION_COUNT = 7;
  localparam int OPT_IDX_W    = 3;
  localparam logic [OPT_IDX_W-1:0] OPT_LAST = OPT_IDX_W'(OPTION_COUNT - 1);

  localparam logic [9:0]  MS_LAST         = 10'd999;
  localparam logic [5:0]  SEC_LAST        = 6'd59;
  localparam logic [5:0]  MIN_LAST        = 6'd59;
  localparam logic [4:0]  HOUR_LAST       = 5'd23;
  localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;

  // Clock value after reset is noon.
  localparam logic [4:0] RESET_HOURS = 5'd12;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_SELECT  = 2'd1,
    MODE_COUNT   = 2'd2,
    MODE_DONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_CLOCK_START  = 2'd0,
    CFG_DOUBLE_CLICK = 2'd1,
    CFG_BLINK_HALF   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } hms_t;

  typedef struct packed {
    logic busy;
    logic done;
    hms_t hms;
  } load_status_t;

  // Duration of each option in minutes; the eighth entry repeats the longest.
  function automatic logic [7:0] option_minutes(input logic [OPT_IDX_W-1:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0: r = 8'd1;
      3'd1: r = 8'd5;
      3'd2: r = 8'd10;
      3'd3: r = 8'd30;
      3'd4: r = 8'd60;
      3'd5: r = 8'd120;
      3'd6: r = 8'd240;
      3'd7: r = 8'd240;
    endcase
    return r;
  endfunction

  // Whole hours of each option's duration.
  function automatic logic [2:0] option_hours(input logic [OPT_IDX_W-1:0] idx);
    logic [2:0] r;
    unique case (idx)
      3'd0, 3'd1, 3'd2, 3'd3: r = 3'd0;
      3'd4:                   r = 3'd1;
      3'd5:                   r = 3'd2;
      3'd6, 3'd7:             r = 3'd4;
    endcase
    return r;
  endfunction

  // Minutes left over after the whole hours of each option's duration.
  function automatic logic [5:0] option_min_part(input logic [OPT_IDX_W-1:0] idx);
    logic [5:0] r;
    unique case (idx)
      3'd0:                   r = 6'd1;
      3'd1:                   r = 6'd5;
      3'd2:                   r = 6'd10;
      3'd3:                   r = 6'd30;
      3'd4, 3'd5, 3'd6, 3'd7: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/encoder_countdown_timer_top.sv]
// Top level of the encoder countdown timer: tick processing, state and result register.
//
// Each input transaction is one millisecond tick carrying the sampled encoder A/B levels
// and the push-button level (0 = pressed). Each tick yields exactly one result
// transaction: the display mode, h:m:s, the selected duration and the blink phase.
// Both channels use valid/stall; a transaction moves at a rising edge where valid is
// high and stall is low.
//
// The accepting edge loads the input register; the edge at which the tick advances loads
// the result register, which presents the result.
// Throughput is one tick per cycle unless stalled: the input and result registers are
// separate stages, so a new tick is taken while a result waits. The input side stalls
// only while the clock is loading or when both stages are full and the receiver stalls.
//
// Configuration writes take effect at the edge where cfg_write_en is high. Writing the
// clock start register runs a two-step seconds-to-h:m:s conversion by constant
// reciprocals that holds in_stall high while it runs; the other registers apply at once.
//
// Synchronous active-high reset puts the block in standby showing 12:00:00, with the
// first option selected, the double-click window at 400 ms and the blink half period
// at 500 ms. Both pipeline stages are emptied.
`default_nettype none

module encoder_countdown_timer_top
  import ect_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        enc_a_level,
  input  wire logic        enc_b_level,
  input  wire logic        button_level,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       mode,
  output logic [4:0]       hours,
  output logic [5:0]       minutes,
  output logic [5:0]       seconds,
  output logic [7:0]       chosen_minutes,
  output logic             blink_on,
  // Configuration write port.
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  // Input register stage.
  logic in_q_valid;
  logic a_q, b_q, btn_q;
  logic in_accept;
  logic advance;

  // Configuration.
  logic [9:0] dbl_ms;
  logic [9:0] blink_half_ms;

  // Mode flags and selection.
  logic                 standby, standby_next;
  logic                 counting, counting_next;
  logic                 finished, finished_next;
  logic [OPT_IDX_W-1:0] option, option_next;
  logic                 prev_a, prev_a_next;
  logic                 prev_btn, prev_btn_next;
  logic [9:0]           since_press, since_press_next;
  logic [9:0]           since_blink, since_blink_next;
  logic                 blink_phase, blink_phase_next;

  // Time-of-day clock kept directly in h:m:s plus milliseconds.
  logic [9:0] clk_ms, clk_ms_next;
  logic [5:0] clk_s, clk_s_next;
  logic [5:0] clk_m, clk_m_next;
  logic [4:0] clk_h, clk_h_next;

  // Time remaining on the countdown, saturating at zero.
  logic [9:0] cd_ms, cd_ms_next;
  logic [5:0] cd_s, cd_s_next;
  logic [5:0] cd_m, cd_m_next;
  logic [2:0] cd_h, cd_h_next;
  logic [9:0] cd_ms_dec;
  logic [5:0] cd_s_dec;
  logic [5:0] cd_m_dec;
  logic [2:0] cd_h_dec;
  logic       cd_zero, cd_dec_zero;

  logic [9:0] since_press_inc, since_blink_inc;
  logic       press;
  logic       a_rise;

  // Next result.
  mode_t      mode_next;
  logic [4:0] hours_next;
  logic [5:0] minutes_next;
  logic [5:0] seconds_next;
  logic       blink_next;

  load_status_t load_status;

  ect_clock_load u_clock_load (
    .clk           (clk),
    .rst           (rst),
    .start         (cfg_write_en && cfg_index == CFG_CLOCK_START),
    .start_seconds (cfg_data),
    .status        (load_status)
  );

  // Handshake. A tick waits in the input register while the clock is being loaded.
  assign advance   = in_q_valid && !load_status.busy && (!out_valid || !out_stall);
  assign in_stall  = load_status.busy || (in_q_valid && !advance);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_accept) begin
        in_q_valid <= 1'b1;
      end else if (advance) begin
        in_q_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_q   <= enc_a_level;
      b_q   <= enc_b_level;
      btn_q <= button_level;
    end
  end

  // Per-tick update.
  always_comb begin
    // Clock advances one millisecond on every tick.
    clk_ms_next = clk_ms;
    clk_s_next  = clk_s;
    clk_m_next  = clk_m;
    clk_h_next  = clk_h;
    if (clk_ms == MS_LAST) begin
      clk_ms_next = 10'd0;
      if (clk_s == SEC_LAST) begin
        clk_s_next = 6'd0;
        if (clk_m == MIN_LAST) begin
          clk_m_next = 6'd0;
          clk_h_next = (clk_h == HOUR_LAST) ? 5'd0 : clk_h + 5'd1;
        end else begin
          clk_m_next = clk_m + 6'd1;
        end
      end else begin
        clk_s_next = clk_s + 6'd1;
      end
    end else begin
      clk_ms_next = clk_ms + 10'd1;
    end

    // Countdown decrements while running, also in standby, and stops at zero.
    cd_zero   = (cd_ms == 10'd0) && (cd_s == 6'd0) && (cd_m == 6'd0) && (cd_h == 3'd0);
    cd_ms_dec = cd_ms;
    cd_s_dec  = cd_s;
    cd_m_dec  = cd_m;
    cd_h_dec  = cd_h;
    if (counting && !cd_zero) begin
      if (cd_ms == 10'd0) begin
        cd_ms_dec = MS_LAST;
        if (cd_s == 6'd0) begin
          cd_s_dec = SEC_LAST;
          if (cd_m == 6'd0) begin
            cd_m_dec = MIN_LAST;
            cd_h_dec = cd_h - 3'd1;
          end else begin
            cd_m_dec = cd_m - 6'd1;
          end
        end else begin
          cd_s_dec = cd_s - 6'd1;
        end
      end else begin
        cd_ms_dec = cd_ms - 10'd1;
      end
    end
    cd_dec_zero = (cd_ms_dec == 10'd0) && (cd_s_dec == 6'd0) &&
                  (cd_m_dec == 6'd0) && (cd_h_dec == 3'd0);
    cd_ms_next = cd_ms_dec;
    cd_s_next  = cd_s_dec;
    cd_m_next  = cd_m_dec;
    cd_h_next  = cd_h_dec;

    since_press_inc = (since_press == 10'h3FF) ? since_press : since_press + 10'd1;
    since_blink_inc = (since_blink == 10'h3FF) ? since_blink : since_blink + 10'd1;

    // A press is a falling edge of the button; a quick second press toggles standby.
    press            = prev_btn && !btn_q;
    prev_btn_next    = btn_q;
    standby_next     = standby ^ (press && (since_press_inc < dbl_ms));
    since_press_next = press ? 10'd0 : since_press_inc;

    counting_next    = counting;
    finished_next    = finished;
    option_next      = option;
    prev_a_next      = prev_a;
    since_blink_next = since_blink_inc;
    blink_phase_next = blink_phase;
    a_rise           = a_q && !prev_a;

    if (!standby_next) begin
      if (!counting && !finished) begin
        // Selecting: each rising edge of A steps the option up or down with wrap.
        if (a_rise) begin
          if (b_q) begin
            option_next = (option == OPT_LAST) ? '0 : option + 1'b1;
          end else begin
            option_next = (option == '0) ? OPT_LAST : option - 1'b1;
          end
        end
        prev_a_next = a_q;
        if (press) begin
          counting_next = 1'b1;
          cd_ms_next    = 10'd0;
          cd_s_next     = 6'd0;
          cd_m_next     = option_min_part(option_next);
          cd_h_next     = option_hours(option_next);
        end
      end else if (counting) begin
        if (press) begin
          counting_next = 1'b0;
        end
        // Expiry wins over a press on the same tick.
        if (cd_dec_zero) begin
          counting_next    = 1'b0;
          finished_next    = 1'b1;
          since_blink_next = 10'd0;
        end
      end else begin
        if (since_blink_inc >= blink_half_ms) begin
          blink_phase_next = !blink_phase;
          since_blink_next = 10'd0;
        end
        if (press) begin
          finished_next = 1'b0;
        end
      end
    end

    // Result fields from the updated state.
    hours_next   = 5'd0;
    minutes_next = 6'd0;
    seconds_next = 6'd0;
    blink_next   = 1'b0;
    priority if (standby_next) begin
      mode_next    = MODE_STANDBY;
      hours_next   = clk_h_next;
      minutes_next = clk_m_next;
      seconds_next = clk_s_next;
    end else if (counting_next) begin
      mode_next    = MODE_COUNT;
      hours_next   = {2'b00, cd_h_next};
      minutes_next = cd_m_next;
      seconds_next = cd_s_next;
    end else if (finished_next) begin
      mode_next  = MODE_DONE;
      blink_next = blink_phase_next;
    end else begin
      mode_next = MODE_SELECT;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      standby       <= 1'b1;
      counting      <= 1'b0;
      finished      <= 1'b0;
      option        <= '0;
      prev_a        <= 1'b1;
      prev_btn      <= 1'b1;
      since_press   <= 10'h3FF;
      since_blink   <= 10'd0;
      blink_phase   <= 1'b0;
      clk_ms        <= 10'd0;
      clk_s         <= 6'd0;
      clk_m         <= 6'd0;
      clk_h         <= RESET_HOURS;
      cd_ms         <= 10'd0;
      cd_s          <= 6'd0;
      cd_m          <= 6'd0;
      cd_h          <= 3'd0;
      dbl_ms        <= 10'd400;
      blink_half_ms <= 10'd500;
    end else begin
      if (advance) begin
        standby     <= standby_next;
        counting    <= counting_next;
        finished    <= finished_next;
        option      <= option_next;
        prev_a      <= prev_a_next;
        prev_btn    <= prev_btn_next;
        since_press <= since_press_next;
        since_blink <= since_blink_next;
        blink_phase <= blink_phase_next;
        cd_ms       <= cd_ms_next;
        cd_s        <= cd_s_next;
        cd_m        <= cd_m_next;
        cd_h        <= cd_h_next;
        clk_ms      <= clk_ms_next;
        clk_s       <= clk_s_next;
        clk_m       <= clk_m_next;
        clk_h       <= clk_h_next;
      end else if (load_status.done) begin
        clk_ms <= 10'd0;
        clk_s  <= load_status.hms.seconds;
        clk_m  <= load_status.hms.minutes;
        clk_h  <= load_status.hms.hours;
      end
      if (cfg_write_en && cfg_index == CFG_DOUBLE_CLICK) begin
        dbl_ms <= cfg_data[9:0];
      end
      if (cfg_write_en && cfg_index == CFG_BLINK_HALF) begin
        blink_half_ms <= cfg_data[9:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      mode           <= mode_next;
      hours          <= hours_next;
      minutes        <= minutes_next;
      seconds        <= seconds_next;
      chosen_minutes <= option_minutes(option_next);
      blink_on       <= blink_next;
    end
  end

  // Running and finished never hold together.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(counting && finished))
    else $error("counting and finished flags both set");

  // The time-of-day counters stay within a day.
  a_clock_range: assert property (@(posedge clk) disable iff (rst)
    clk_ms <= MS_LAST && clk_s <= SEC_LAST && clk_m <= MIN_LAST && clk_h <= HOUR_LAST)
    else $error("time-of-day clock out of range");

  // The countdown digits stay in range and never exceed the longest duration.
  a_countdown_range: assert property (@(posedge clk) disable iff (rst)
    cd_ms <= MS_LAST && cd_s <= SEC_LAST && cd_m <= MIN_LAST &&
    (cd_h < 3'd4 || (cd_h == 3'd4 && cd_m == 6'd0 && cd_s == 6'd0 && cd_ms == 10'd0)))
    else $error("countdown value out of range");

  // A new result only appears when a tick was waiting in the input register.
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_q_valid) && !$past(load_status.busy))
    else $error("result produced without a pending tick");

endmodule

`default_nettype wire

[hdl/ect_clock_load.sv]
// Converts a loaded second-of-day value into hours, minutes and seconds.
`default_nettype none

module ect_clock_load
  import ect_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [16:0]  start_seconds,
  output load_status_t      status
);

  localparam logic [1:0] HOUR_STEP = 2'd0;
  localparam logic [1:0] MIN_STEP  = 2'd1;
  localparam logic [1:0] DONE_STEP = 2'd2;

  // ceil(2^20 / 225): exact quotient for every dividend below 5400.
  localparam logic [24:0] HOUR_RECIP = 25'd4661;
  // ceil(2^14 / 15): exact quotient for every dividend below 900.
  localparam logic [19:0] MIN_RECIP  = 20'd1093;

  logic        busy;
  logic [1:0]  step;
  logic [16:0] rem;
  logic [4:0]  hrs;
  logic [5:0]  mins;
  logic [24:0] hour_prod;
  logic [4:0]  hour_q;
  logic [16:0] hour_secs;
  logic [19:0] min_prod;
  logic [5:0]  min_q;
  logic [11:0] min_secs;

  // Division by 3600 and by 60 through constant reciprocals. Dividing by 3600 is the
  // same as dropping four bits and dividing by 225; dividing by 60 is dropping two bits
  // and dividing by 15. Hours are taken in the first step, minutes in the second.
  always_comb begin
    hour_prod = 25'(rem[16:4]) * HOUR_RECIP;
    hour_q    = hour_prod[24:20];
    hour_secs = 17'(hour_q) * 17'd3600;
    min_prod  = 20'(rem[11:2]) * MIN_RECIP;
    min_q     = min_prod[19:14];
    min_secs  = 12'(min_q) * 12'd60;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == DONE_STEP) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= HOUR_STEP;
      hrs  <= 5'd0;
      mins <= 6'd0;
      if (start_seconds >= SECONDS_PER_DAY) begin
        rem <= start_seconds - SECONDS_PER_DAY;
      end else begin
        rem <= start_seconds;
      end
    end else if (busy) begin
      if (step == HOUR_STEP) begin
        hrs  <= hour_q;
        rem  <= rem - hour_secs;
        step <= MIN_STEP;
      end else if (step == MIN_STEP) begin
        mins <= min_q;
        rem  <= rem - {5'd0, min_secs};
        step <= DONE_STEP;
      end
    end
  end

  assign status.busy        = busy;
  assign status.done        = busy && (step == DONE_STEP);
  assign status.hms.hours   = hrs;
  assign status.hms.minutes = mins;
  assign status.hms.seconds = rem[5:0];

endmodule

`default_nettype wire
